@@ hdl/ows_pkg.sv @@
// Shared types, codes and constants for the 1-Wire slave emulator.
package ows_pkg;

  // Bits in the device identity; the ROM register itself is always 64 bits.
  localparam int unsigned ID_BITS     = 64;
  localparam int unsigned MATCH_BYTES = (ID_BITS + 7) / 8;

  localparam logic [7:0] ID_BITS_C     = 8'(ID_BITS);
  localparam logic [4:0] MATCH_BYTES_C = 5'(MATCH_BYTES);

  // ROM command codes
  localparam logic [7:0] CMD_READ_ROM   = 8'h33;
  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_MATCH_ROM  = 8'h55;
  localparam logic [7:0] CMD_SEARCH_ROM = 8'hF0;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROM_ID       = 2'd0,
    CFG_BIT_ONE_LIM  = 2'd1,
    CFG_RESET_MIN    = 2'd2,
    CFG_RESET_MAX    = 2'd3
  } cfg_idx_e;

  // Configuration reset values
  localparam logic [63:0] ROM_ID_RST      = 64'hF602_1830_F375_FF28;
  localparam logic [7:0]  BIT_ONE_LIM_RST = 8'd35;
  localparam logic [15:0] RESET_MIN_RST   = 16'd460;
  localparam logic [15:0] RESET_MAX_RST   = 16'd600;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_PRESENCE = 3'd1,
    MODE_COMMAND  = 3'd2,
    MODE_SEARCH   = 3'd3,
    MODE_MATCH    = 3'd4,
    MODE_TRANSMIT = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    DRIVE_NONE     = 2'd0,
    DRIVE_PRESENCE = 2'd1,
    DRIVE_ZERO     = 2'd2
  } drive_e;

  typedef struct packed {
    mode_e       mode;
    logic [6:0]  bit_count;
    logic [3:0]  byte_index;
    logic [7:0]  shift_byte;
    logic [1:0]  search_phase;
  } slave_state_t;

  typedef struct packed {
    logic [63:0] rom_id;
    logic [7:0]  bit_one_limit;
    logic [15:0] reset_min;
    logic [15:0] reset_max;
  } slave_cfg_t;

  typedef struct packed {
    drive_e      drive;
    mode_e       mode;
    logic        command_seen;
    logic [7:0]  command_code;
    logic        selected;
  } slave_res_t;

  localparam slave_state_t STATE_CLEAR = '{
    mode:         MODE_IDLE,
    bit_count:    7'd0,
    byte_index:   4'd0,
    shift_byte:   8'd0,
    search_phase: 2'd0
  };

endpackage

@@ hdl/ows_step.sv @@
// Next-state and result logic for one bus edge.
module ows_step import ows_pkg::*; (
  input  slave_state_t state_i,
  input  slave_cfg_t   cfg_i,
  input  logic         line_level_i,
  input  logic [15:0]  elapsed_us_i,
  output slave_state_t state_o,
  output slave_res_t   res_o
);

  logic        bit_val;
  logic        is_reset;
  logic [7:0]  shift_acc;
  logic [6:0]  bit_inc;
  logic        search_rb;
  logic [5:0]  tx_idx;
  logic        tx_rb;
  logic [7:0]  want_byte;
  logic [3:0]  tx_bit_nxt;
  logic [3:0]  tx_byte_nxt;
  logic [7:0]  tx_pos;

  assign bit_val   = (elapsed_us_i < {8'd0, cfg_i.bit_one_limit});
  assign is_reset  = line_level_i && (elapsed_us_i > cfg_i.reset_min)
                     && (elapsed_us_i < cfg_i.reset_max);
  assign shift_acc = state_i.shift_byte | (8'(bit_val) << state_i.bit_count[2:0]);
  assign bit_inc   = state_i.bit_count + 7'd1;
  assign search_rb = cfg_i.rom_id[state_i.bit_count[5:0]];
  assign tx_idx    = {state_i.byte_index[2:0], state_i.bit_count[2:0]};
  assign tx_rb     = cfg_i.rom_id[tx_idx];
  assign want_byte = cfg_i.rom_id[{state_i.byte_index[2:0], 3'b000} +: 8];

  // Read ROM position after this bit
  always_comb begin
    if (bit_inc >= 7'd8) begin
      tx_bit_nxt  = 4'd0;
      tx_byte_nxt = state_i.byte_index + 4'd1;
    end else begin
      tx_bit_nxt  = bit_inc[3:0];
      tx_byte_nxt = state_i.byte_index;
    end
    tx_pos = {1'b0, tx_byte_nxt, 3'b000} + {4'd0, tx_bit_nxt};
  end

  always_comb begin
    state_o = state_i;
    res_o   = '{drive: DRIVE_NONE, mode: MODE_IDLE, command_seen: 1'b0,
                command_code: 8'd0, selected: 1'b0};
    if (is_reset) begin
      state_o      = STATE_CLEAR;
      state_o.mode = MODE_PRESENCE;
      res_o.drive  = DRIVE_PRESENCE;
    end else begin
      unique case (state_i.mode)
        MODE_PRESENCE: begin
          state_o.mode = MODE_COMMAND;
        end
        MODE_COMMAND: begin
          if (line_level_i) begin
            state_o.shift_byte = shift_acc;
            state_o.bit_count  = bit_inc;
            if (bit_inc >= 7'd8) begin
              res_o.command_seen = 1'b1;
              res_o.command_code = shift_acc;
              state_o            = STATE_CLEAR;
              priority if (shift_acc == CMD_READ_ROM)   state_o.mode = MODE_TRANSMIT;
              else if (shift_acc == CMD_SKIP_ROM)        state_o.mode = MODE_COMMAND;
              else if (shift_acc == CMD_MATCH_ROM)       state_o.mode = MODE_MATCH;
              else if (shift_acc == CMD_SEARCH_ROM)      state_o.mode = MODE_SEARCH;
              else                                       state_o.mode = MODE_IDLE;
            end
          end
        end
        MODE_SEARCH: begin
          if (!line_level_i) begin
            unique case (state_i.search_phase)
              2'd0: begin
                if (!search_rb) res_o.drive = DRIVE_ZERO;
                state_o.search_phase = 2'd1;
              end
              2'd1: begin
                if (search_rb) res_o.drive = DRIVE_ZERO;
                state_o.search_phase = 2'd2;
              end
              2'd2: state_o.search_phase = 2'd3;
              default: ;
            endcase
          end else if (state_i.search_phase == 2'd3) begin
            if (bit_val != search_rb) begin
              state_o = STATE_CLEAR;
            end else begin
              state_o.bit_count    = bit_inc;
              state_o.search_phase = 2'd0;
              if ({1'b0, bit_inc} >= ID_BITS_C) begin
                state_o.mode      = MODE_COMMAND;
                state_o.bit_count = 7'd0;
                res_o.selected    = 1'b1;
              end
            end
          end
        end
        MODE_MATCH: begin
          if (line_level_i) begin
            state_o.shift_byte = shift_acc;
            state_o.bit_count  = bit_inc;
            if (bit_inc >= 7'd8) begin
              if (shift_acc != want_byte) begin
                state_o = STATE_CLEAR;
              end else begin
                state_o.byte_index = state_i.byte_index + 4'd1;
                state_o.bit_count  = 7'd0;
                state_o.shift_byte = 8'd0;
                if ({1'b0, state_i.byte_index} + 5'd1 >= MATCH_BYTES_C) begin
                  state_o.mode   = MODE_COMMAND;
                  res_o.selected = 1'b1;
                end
              end
            end
          end
        end
        MODE_TRANSMIT: begin
          if (!line_level_i) begin
            if (!tx_rb) res_o.drive = DRIVE_ZERO;
            state_o.bit_count  = {3'd0, tx_bit_nxt};
            state_o.byte_index = tx_byte_nxt;
            if (tx_pos >= ID_BITS_C) state_o = STATE_CLEAR;
          end
        end
        default: ;
      endcase
    end
    res_o.mode = state_o.mode;
  end

endmodule

@@ hdl/one_wire_slave_emulator_unit.sv @@
// Top level of the edge-driven 1-Wire slave emulator with ROM commands.
// Each input transaction is one bus edge (new line level plus microseconds
// since the previous edge); each edge yields exactly one result transaction
// carrying the pulse request, the mode after the edge, any completed command
// byte and a selection flag. The block takes one edge per clock cycle while
// the result side keeps taking: an edge lands in an input register, the step
// logic resolves it combinationally against the slave state, and the result
// waits in an output register. A stalled result holds the input register;
// the input accepts again as soon as the output register can move on.
// Configuration writes (ROM identity, one-bit limit, reset window) take
// effect on the next edge and should only be made while no edge is in flight.
module one_wire_slave_emulator_unit import ows_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // edge input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        line_level_i,
  input  logic [15:0] elapsed_us_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  drive_o,
  output logic [2:0]  mode_o,
  output logic        command_seen_o,
  output logic [7:0]  command_code_o,
  output logic        selected_o
);

  slave_cfg_t   cfg_q;
  slave_state_t state_q, state_d;
  slave_res_t   res_d, res_q;

  logic         in_vld_q;
  logic         level_q;
  logic [15:0]  dur_q;
  logic         out_vld_q;
  logic         advance;

  // Move the held edge on when the output register is free or being drained
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_id        <= ROM_ID_RST;
      cfg_q.bit_one_limit <= BIT_ONE_LIM_RST;
      cfg_q.reset_min     <= RESET_MIN_RST;
      cfg_q.reset_max     <= RESET_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROM_ID:      cfg_q.rom_id        <= cfg_wdata_i;
        CFG_BIT_ONE_LIM: cfg_q.bit_one_limit <= cfg_wdata_i[7:0];
        CFG_RESET_MIN:   cfg_q.reset_min     <= cfg_wdata_i[15:0];
        CFG_RESET_MAX:   cfg_q.reset_max     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the edge until the step logic consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      level_q <= line_level_i;
      dur_q   <= elapsed_us_i;
    end
  end

  ows_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .line_level_i (level_q),
    .elapsed_us_i (dur_q),
    .state_o      (state_d),
    .res_o        (res_d)
  );

  // Slave state advances only when an edge is resolved
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_CLEAR;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign drive_o        = res_q.drive;
  assign mode_o         = res_q.mode;
  assign command_seen_o = res_q.command_seen;
  assign command_code_o = res_q.command_code;
  assign selected_o     = res_q.selected;

endmodule
